// File: sv/double_ended_queue_defines.svh
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared checking macros for the queue modules. Each macro checks a property
// on the rising edge of clk, with checking held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque check failed in this cycle");
// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque check failed one cycle later");
`else
`define DEQ_ASSERT_SAME(label, ante, cons)
`define DEQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Command codes, word constants and the control/status bundles that pass
// between the queue controller and its datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Width of one stored word and of the answer.
  localparam int WORD_W     = 32;
  // Width of the command field.
  localparam int CMD_W      = 3;

  // Answer given by a pop or peek on an empty queue.
  localparam logic [WORD_W-1:0] ANSWER_NONE  = '1;
  localparam logic [WORD_W-1:0] ANSWER_TRUE  = WORD_W'(1);
  localparam logic [WORD_W-1:0] ANSWER_FALSE = '0;

  // Queue commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SIZE       = 3'd4,
    CMD_EMPTY      = 3'd5,
    CMD_FRONT      = 3'd6,
    CMD_BACK       = 3'd7
  } cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // an input item is taken this cycle
    logic load_out;  // load the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_push;   // the offered item is a push and gives no result
  } dp_stat_t;

endpackage

// File: sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit words in a ring memory, with push, pop and
// peek at both ends, size and empty queries, and a sticky overflow flag.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one command per item: in_tuser holds the
//   command code and in_tdata the word to push (ignored by other commands).
//   Pushes give no result. Every other command gives one result item on the
//   output stream: out_tdata holds the answer (popped or peeked word, -1 when
//   empty, the count, or the empty flag) and out_tuser the overflow flag.
//   A push is taken and the block is ready again right after it. A command
//   with a result first issues the ring memory read and updates the
//   pointers in its accepting cycle, then waits in the response state
//   until the output register is free and loads it; the answer is offered
//   in the cycle after that load. The output register holds a result while
//   the receiver stalls and the block meanwhile takes the next item; a
//   second result then waits until the register is free. Reset empties the
//   queue and clears the overflow flag; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [2:0]  in_tuser,   // [2:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] answer
  output logic [0:0]  out_tuser   // [0] overflowed
);

  deq_pkg::ctrl_cmd_t ctrl_cmd;
  deq_pkg::dp_stat_t  dp_stat;
  logic               ovf_out;

  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (dp_stat),
    .cmd        (ctrl_cmd)
  );

  deq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (ctrl_cmd),
    .stat           (dp_stat),
    .in_command     (deq_pkg::cmd_t'(in_tuser)),
    .in_value       (in_tdata),
    .out_answer     (out_tdata),
    .out_overflowed (ovf_out)
  );

  assign out_tuser[0] = ovf_out;

endmodule

// File: sv/deq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data. The read data
// holds its value in cycles without a read enable.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences one item at a time: takes an item, and for commands that give a
// result waits in the response state for the memory read before loading
// the output register once it is free.
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module deq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  deq_pkg::dp_stat_t    stat,
  output deq_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   load_out;

  // Handshake decode.
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tready && in_tvalid;
  assign load_out  = (state_r == S_RESP) && (!out_valid_r || out_tready);

  // Next state and output valid.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept && !stat.is_push) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (load_out) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign cmd.accept   = accept;
  assign cmd.load_out = load_out;

  // A loaded result is offered in the next cycle.
  `DEQ_ASSERT_NEXT(a_load_gives_valid, load_out, out_tvalid)
  // An item that gives a result moves the controller to the response state.
  `DEQ_ASSERT_NEXT(a_result_item_waits, accept && !stat.is_push, state_r == S_RESP)
  // A pending response is not dropped while the output register is busy.
  `DEQ_ASSERT_NEXT(a_resp_holds, (state_r == S_RESP) && !load_out, state_r == S_RESP)

endmodule

// File: sv/deq_dp.sv
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring memory with head and tail slot pointers, the element count, the
// sticky overflow flag and the output register.
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module deq_dp #(
  parameter int CAPACITY = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  deq_pkg::ctrl_cmd_t            cmd,
  output deq_pkg::dp_stat_t             stat,
  input  deq_pkg::cmd_t                 in_command,
  input  logic [deq_pkg::WORD_W-1:0]    in_value,
  output logic [deq_pkg::WORD_W-1:0]    out_answer,
  output logic                          out_overflowed
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);

  logic [AW-1:0]              head_r, head_nxt;
  logic [AW-1:0]              tail_r, tail_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       use_ram_r, use_ram_nxt;
  logic [deq_pkg::WORD_W-1:0] imm_ans_r, imm_ans_nxt;
  logic [deq_pkg::WORD_W-1:0] answer_r;
  logic                       ovf_out_r;

  logic [AW-1:0]              head_inc, head_dec, tail_inc, tail_dec;
  logic                       is_full, is_empty;
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_addr;
  logic [deq_pkg::WORD_W-1:0] ram_rdata;

  // Neighbor slots with wraparound; the tail always sits one slot before
  // head plus count.
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + AW'(1);
  assign head_dec = (head_r == '0) ? LAST_SLOT : head_r - AW'(1);
  assign tail_inc = (tail_r == LAST_SLOT) ? '0 : tail_r + AW'(1);
  assign tail_dec = (tail_r == '0) ? LAST_SLOT : tail_r - AW'(1);
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);

  assign stat.is_push = (in_command == deq_pkg::CMD_PUSH_FRONT) ||
                        (in_command == deq_pkg::CMD_PUSH_BACK);

  // Command decode at the accepted item: memory access and pointer update.
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    use_ram_nxt = use_ram_r;
    imm_ans_nxt = imm_ans_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = head_r;
    if (cmd.accept) begin
      use_ram_nxt = 1'b0;
      imm_ans_nxt = deq_pkg::ANSWER_NONE;
      case (in_command)
        deq_pkg::CMD_PUSH_FRONT: begin
          if (is_full) begin
            ovf_nxt = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_addr  = head_dec;
            head_nxt  = head_dec;
            count_nxt = count_r + CW'(1);
          end
        end
        deq_pkg::CMD_PUSH_BACK: begin
          if (is_full) begin
            ovf_nxt = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_addr  = tail_inc;
            tail_nxt  = tail_inc;
            count_nxt = count_r + CW'(1);
          end
        end
        deq_pkg::CMD_POP_FRONT: begin
          if (!is_empty) begin
            ram_re      = 1'b1;
            ram_addr    = head_r;
            use_ram_nxt = 1'b1;
            head_nxt    = head_inc;
            count_nxt   = count_r - CW'(1);
          end
        end
        deq_pkg::CMD_POP_BACK: begin
          if (!is_empty) begin
            ram_re      = 1'b1;
            ram_addr    = tail_r;
            use_ram_nxt = 1'b1;
            tail_nxt    = tail_dec;
            count_nxt   = count_r - CW'(1);
          end
        end
        deq_pkg::CMD_SIZE: begin
          imm_ans_nxt = deq_pkg::WORD_W'(count_r);
        end
        deq_pkg::CMD_EMPTY: begin
          imm_ans_nxt = is_empty ? deq_pkg::ANSWER_TRUE : deq_pkg::ANSWER_FALSE;
        end
        deq_pkg::CMD_FRONT: begin
          if (!is_empty) begin
            ram_re      = 1'b1;
            ram_addr    = head_r;
            use_ram_nxt = 1'b1;
          end
        end
        deq_pkg::CMD_BACK: begin
          if (!is_empty) begin
            ram_re      = 1'b1;
            ram_addr    = tail_r;
            use_ram_nxt = 1'b1;
          end
        end
        default: begin
          use_ram_nxt = 1'b0;
        end
      endcase
    end
  end

  // Queue pointers, count and overflow flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= LAST_SLOT;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Pending answer and the output register.
  always_ff @(posedge clk) begin
    use_ram_r <= use_ram_nxt;
    imm_ans_r <= imm_ans_nxt;
    if (cmd.load_out) begin
      answer_r  <= use_ram_r ? ram_rdata : imm_ans_r;
      ovf_out_r <= ovf_r;
    end
  end

  deq_ram #(
    .WIDTH (deq_pkg::WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (in_value),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  assign out_answer     = answer_r;
  assign out_overflowed = ovf_out_r;

  // The count never passes the capacity.
  `DEQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= FULL_CNT)
  // The overflow flag is sticky until reset.
  `DEQ_ASSERT_NEXT(a_ovf_sticky, ovf_r, ovf_r)
  // A memory write only happens when there is room.
  `DEQ_ASSERT_SAME(a_write_has_room, ram_we, !is_full && cmd.accept)

endmodule
